// File: src/fia_pkg.sv
// Shared types and constants for the flagged integer ALU.
`default_nettype none

package fia_pkg;

    localparam int DATA_BITS  = 32;   // width of the result ports
    localparam int A_BITS     = 64;   // width of operand_a / dividend
    localparam int DIV_STEPS  = 2;    // quotient bits retired per cycle
    localparam int DIV_CYCLES = A_BITS / DIV_STEPS;
    localparam int CNT_BITS   = $clog2(DIV_CYCLES);

    typedef enum logic [3:0] {
        FUNC_ADD = 4'd0,
        FUNC_SUB = 4'd1,
        FUNC_MUL = 4'd2,
        FUNC_DIV = 4'd3,
        FUNC_MOD = 4'd4,
        FUNC_AND = 4'd5,
        FUNC_OR  = 4'd6,
        FUNC_XOR = 4'd7,
        FUNC_ASL = 4'd8,
        FUNC_ROT = 4'd9,
        FUNC_INC = 4'd10,
        FUNC_DEC = 4'd11,
        FUNC_NOT = 4'd12
    } func_t;

    typedef struct packed {
        logic borrow;
        logic carry;
        logic overflow;
        logic negative;
        logic zero;
    } flags_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic mul_step;
        logic div_step;
        logic commit;
    } fia_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic op_div;
        logic op_mul;
        logic out_free;
    } fia_sts_t;

endpackage

`default_nettype wire

// File: src/fia_ctrl.sv
// Sequencing state machine for the flagged integer ALU.
`default_nettype none

module fia_ctrl
    import fia_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire fia_sts_t sts,
    output fia_cmd_t      cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    count_next = '0;
                    if (sts.op_div)
                        state_next = S_DIV;
                    else if (sts.op_mul)
                        state_next = S_MUL;
                    else
                        state_next = S_DONE;
                end
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                state_next   = S_DONE;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                count_next   = count_reg + 1'b1;
                if (count_reg == CNT_BITS'(DIV_CYCLES - 1))
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                // wait for the output register to free up
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: src/fia_dp.sv
// Datapath: operand registers, multiplier, radix-4 divider, result and flag logic.
`default_nettype none

module fia_dp
    import fia_pkg::*;
#(
    parameter int WORD_BITS = 32
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [3:0]           func,
    input  wire logic [A_BITS-1:0]    operand_a,
    input  wire logic [DATA_BITS-1:0] operand_b,
    input  wire fia_cmd_t             cmd,
    output fia_sts_t                  sts,
    input  wire logic                 out_ready,
    output logic                      out_valid,
    output logic [DATA_BITS-1:0]      result_low,
    output logic [DATA_BITS-1:0]      result_high,
    output flags_t                    flags
);

    localparam int W = WORD_BITS;

    // five-bit amount modulo W, at most four subtractions
    function automatic logic [4:0] rot_amount(input logic [4:0] amt);
        logic [4:0] k;
        k = amt;
        for (int i = 0; i < 4; i++)
        begin
            if ({1'b0, k} >= 6'(W))
                k = 5'({1'b0, k} - 6'(W));
        end
        return k;
    endfunction

    func_t               func_reg;
    logic [W-1:0]        a_reg;
    logic [W-1:0]        b_reg;
    logic [W-1:0]        ub_reg;
    logic [W-1:0]        rem_reg, rem_next;
    logic [A_BITS-1:0]   dvd_reg, dvd_next;
    logic                na_reg;
    logic                nb_reg;
    logic signed [2*W-1:0] prod_reg;
    logic signed [2*W-1:0] prod_mul;
    logic signed [W-1:0] a_s;
    logic signed [W-1:0] b_s;
    logic                out_valid_reg;
    logic [DATA_BITS-1:0] result_low_reg;
    logic [DATA_BITS-1:0] result_high_reg;
    flags_t              flags_reg, flags_next;
    logic [W-1:0]        r;
    logic [W-1:0]        hi;
    logic [W:0]          sum_w;
    logic [W:0]          diff_w;
    logic [W-1:0]        sign_w;
    logic [W-1:0]        q_w;
    logic [4:0]          rot_k;
    logic [2*W-1:0]      rot_wide;
    logic [W-1:0]        b_in;

    assign b_in       = operand_b[W-1:0];
    assign sts.op_div = (func == FUNC_DIV) || (func == FUNC_MOD);
    assign sts.op_mul = (func == FUNC_MUL);
    assign sts.out_free = !out_valid_reg || out_ready;

    assign a_s      = a_reg;
    assign b_s      = b_reg;
    assign prod_mul = a_s * b_s;

    // two restoring steps per cycle
    always_comb
    begin
        logic [W:0] t;
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            t        = {rem_next, dvd_next[A_BITS-1]};
            dvd_next = {dvd_next[A_BITS-2:0], 1'b0};
            if (t >= {1'b0, ub_reg})
            begin
                rem_next    = W'(t - {1'b0, ub_reg});
                dvd_next[0] = 1'b1;
            end
            else
            begin
                rem_next = t[W-1:0];
            end
        end
    end

    assign sign_w   = {1'b1, {(W-1){1'b0}}};
    assign sum_w    = {1'b0, a_reg} + {1'b0, b_reg};
    assign diff_w   = {1'b0, a_reg} - {1'b0, b_reg};
    assign q_w      = dvd_reg[W-1:0];
    assign rot_k    = rot_amount(b_reg[4:0]);
    assign rot_wide = {a_reg, a_reg} << rot_k;

    always_comb
    begin
        r          = '0;
        hi         = '0;
        flags_next = flags_reg;
        unique case (func_reg)
            FUNC_ADD:
            begin
                r                   = sum_w[W-1:0];
                flags_next.carry    = sum_w[W];
                flags_next.overflow = (a_reg[W-1] == b_reg[W-1]) && (r[W-1] != a_reg[W-1]);
            end
            FUNC_SUB:
            begin
                r                   = diff_w[W-1:0];
                flags_next.borrow   = diff_w[W];
                flags_next.overflow = (a_reg[W-1] != b_reg[W-1]) && (r[W-1] != a_reg[W-1]);
            end
            FUNC_MUL:
            begin
                r  = prod_reg[W-1:0];
                hi = prod_reg[2*W-1:W];
            end
            FUNC_DIV:
            begin
                if (ub_reg == '0)
                    r = '0;
                else if (na_reg != nb_reg)
                    r = W'(-q_w);
                else
                    r = q_w;
            end
            FUNC_MOD:
            begin
                if (ub_reg == '0)
                    r = '0;
                else if (na_reg)
                    r = W'(-rem_reg);
                else
                    r = rem_reg;
            end
            FUNC_AND: r = a_reg & b_reg;
            FUNC_OR:  r = a_reg | b_reg;
            FUNC_XOR: r = a_reg ^ b_reg;
            FUNC_ASL: r = (a_reg << b_reg[4:0]) | (a_reg & sign_w);
            FUNC_ROT: r = rot_wide[2*W-1:W];
            FUNC_INC:
            begin
                r                   = W'(a_reg + 1'b1);
                flags_next.overflow = (a_reg == ~sign_w);
                flags_next.carry    = (r == '0);
            end
            FUNC_DEC:
            begin
                r                   = W'(a_reg - 1'b1);
                flags_next.overflow = (a_reg == sign_w);
                flags_next.borrow   = (a_reg == '0);
            end
            FUNC_NOT: r = ~a_reg;
            default:
            begin
                r  = '0;
                hi = '0;
            end
        endcase

        // zero / negative: full product for mul, zero only for rot
        if (func_reg == FUNC_MUL)
        begin
            flags_next.zero     = (prod_reg == '0);
            flags_next.negative = prod_reg[2*W-1];
        end
        else if (func_reg == FUNC_ROT)
        begin
            flags_next.zero = (r == '0);
        end
        else if (func_reg <= FUNC_NOT)
        begin
            flags_next.zero     = (r == '0);
            flags_next.negative = r[W-1];
        end
    end

    // operand and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func_t'(func);
            a_reg    <= operand_a[W-1:0];
            b_reg    <= b_in;
            na_reg   <= operand_a[A_BITS-1];
            nb_reg   <= b_in[W-1];
            ub_reg   <= b_in[W-1] ? W'(-b_in) : b_in;
            dvd_reg  <= operand_a[A_BITS-1] ? A_BITS'(-operand_a) : operand_a;
            rem_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
        if (cmd.mul_step)
            prod_reg <= prod_mul;
        if (cmd.commit)
        begin
            result_low_reg  <= DATA_BITS'(r);
            result_high_reg <= DATA_BITS'(hi);
        end
    end

    // output valid and status flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
                flags_reg     <= flags_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_low  = result_low_reg;
    assign result_high = result_high_reg;
    assign flags       = flags_reg;

endmodule

`default_nettype wire

// File: src/flagged_integer_alu_core.sv
// Top level of the flagged integer ALU: controller plus datapath.
// From accept to result valid: load, then multiply (mul) or divide loop (div/mod),
// then done, which waits for a free output register. Div/mod use the shared
// divider that retires two quotient bits per cycle over the 64-bit dividend.
// A new item is taken while the previous result still waits in the output register.
// Reset (rst_n low, async) clears the controller, the output valid and all five flags.
`default_nettype none

module flagged_integer_alu_core
    import fia_pkg::*;
#(
    parameter int WORD_BITS = 32
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    // input channel
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [3:0]           func,
    input  wire logic [A_BITS-1:0]    operand_a,
    input  wire logic [DATA_BITS-1:0] operand_b,

    // output channel
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [DATA_BITS-1:0]      result_low,
    output logic [DATA_BITS-1:0]      result_high,
    output logic                      flag_zero,
    output logic                      flag_negative,
    output logic                      flag_overflow,
    output logic                      flag_carry,
    output logic                      flag_borrow
);

    fia_cmd_t cmd;
    fia_sts_t sts;
    flags_t   flags;

    // Controller: one item at a time. Idle -> (mul | div loop) -> done,
    // and done holds until the output register can take the result.
    fia_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: operand capture, registered multiply, iterative divide,
    // final result mux, flag update and output register.
    fia_dp #(
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .func        (func),
        .operand_a   (operand_a),
        .operand_b   (operand_b),
        .cmd         (cmd),
        .sts         (sts),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .result_low  (result_low),
        .result_high (result_high),
        .flags       (flags)
    );

    // flags shown with a result are the status register after that result
    assign flag_zero     = flags.zero;
    assign flag_negative = flags.negative;
    assign flag_overflow = flags.overflow;
    assign flag_carry    = flags.carry;
    assign flag_borrow   = flags.borrow;

`ifndef SYNTHESIS
    // only one datapath command at a time
    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.mul_step, cmd.div_step, cmd.commit}))
        else $error("more than one datapath command active");

    // a result is only committed into a free output register
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid || out_ready))
        else $error("commit overwrote a pending result");

    // a commit always presents a result in the next cycle
    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid)
        else $error("committed result not presented");

    // after a transfer in, the block stops taking items until it finishes
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item taken while busy");
`endif

endmodule

`default_nettype wire
